[rtl/lmt_pkg.sv]
// Package for the LCD mode timing and register block.
// Holds the item types, the register map, the operation codes and the reset values.
// No dependencies.
package lmt_pkg;

    typedef struct packed {
        logic [1:0]  operation;
        logic [6:0]  tick_dots;
        logic [15:0] reg_address;
        logic [7:0]  write_data;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       vblank_irq;
        logic       stat_irq;
        logic       line_drawn;
        logic       frame_done;
    } t_out_item;

    // Display phase, one-hot.
    typedef enum logic [3:0] {
        PH_HBLANK = 4'b0001,
        PH_VBLANK = 4'b0010,
        PH_SCAN   = 4'b0100,
        PH_DRAW   = 4'b1000
    } t_phase;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [15:0] ADDR_CONTROL  = 16'hFF40;
    localparam logic [15:0] ADDR_STATUS   = 16'hFF41;
    localparam logic [15:0] ADDR_SCROLL_Y = 16'hFF42;
    localparam logic [15:0] ADDR_SCROLL_X = 16'hFF43;
    localparam logic [15:0] ADDR_LINE     = 16'hFF44;
    localparam logic [15:0] ADDR_LYC      = 16'hFF45;
    localparam logic [15:0] ADDR_DMA      = 16'hFF46;
    localparam logic [15:0] ADDR_BGP      = 16'hFF47;
    localparam logic [15:0] ADDR_OBP0     = 16'hFF48;
    localparam logic [15:0] ADDR_OBP1     = 16'hFF49;
    localparam logic [15:0] ADDR_WIN_Y    = 16'hFF4A;
    localparam logic [15:0] ADDR_WIN_X    = 16'hFF4B;

    localparam logic [7:0] RST_CONTROL = 8'h91;
    localparam logic [7:0] RST_STATUS  = 8'h85;
    localparam logic [7:0] RST_BGP     = 8'hFC;
    localparam logic [7:0] RST_OBP     = 8'hFF;
    localparam logic [7:0] READ_UNMAPPED = 8'hFF;

    localparam logic [9:0] DOTS_SCAN   = 10'd80;
    localparam logic [9:0] DOTS_DRAW   = 10'd172;
    localparam logic [9:0] DOTS_HBLANK = 10'd204;
    localparam logic [9:0] DOTS_LINE   = 10'd456;
    localparam logic [7:0] LINE_VBLANK = 8'd144;
    localparam logic [7:0] LINE_LAST   = 8'd153;

    // Two-bit mode code as seen in the status register.
    function automatic logic [1:0] mode_code(input t_phase ph);
        logic [1:0] code;
        code = 2'd0;
        unique case (ph)
            PH_HBLANK: code = 2'd0;
            PH_VBLANK: code = 2'd1;
            PH_SCAN:   code = 2'd2;
            PH_DRAW:   code = 2'd3;
            default:   code = 2'd0;
        endcase
        return code;
    endfunction

endpackage

[rtl/lmt_in_reg.sv]
// Input register stage of the LCD mode timing block.
// Depends on lmt_pkg for the input item type.
module lmt_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lmt_pkg::t_in_item i_item,
    output logic              o_valid,
    output lmt_pkg::t_in_item o_item,
    input  logic              i_take
);
    import lmt_pkg::*;

    logic     r_valid;
    t_in_item r_item;
    logic     n_valid;

    // The held item may be replaced in the same cycle in which it moves on.
    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/lmt_engine.sv]
// Register file and dot/line/mode sequencer of the LCD mode timing block.
// Depends on lmt_pkg for item types, register map, phase type and constants.
module lmt_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  lmt_pkg::t_in_item  i_item,
    output lmt_pkg::t_out_item o_result
);
    import lmt_pkg::*;

    logic [7:0] r_control, r_status, r_scy, r_scx, r_line, r_lyc, r_dma;
    logic [7:0] r_bgp, r_obp0, r_obp1, r_win_y, r_win_x;
    t_phase     r_phase;
    logic [8:0] r_dot;

    logic [7:0] n_control, n_status, n_scy, n_scx, n_line, n_lyc, n_dma;
    logic [7:0] n_bgp, n_obp0, n_obp1, n_win_y, n_win_x;
    t_phase     n_phase;
    logic [8:0] n_dot;

    logic [9:0] sum;
    logic [9:0] dot_left;
    logic [7:0] line_inc;
    logic [7:0] line_new;
    logic       cmp_now;
    t_out_item  res;

    always_comb begin
        n_control = r_control; n_status = r_status; n_scy = r_scy; n_scx = r_scx;
        n_line = r_line; n_lyc = r_lyc; n_dma = r_dma; n_bgp = r_bgp;
        n_obp0 = r_obp0; n_obp1 = r_obp1; n_win_y = r_win_y; n_win_x = r_win_x;
        n_phase = r_phase;
        n_dot = r_dot;
        res = '0;
        sum = {1'b0, r_dot} + {3'b000, i_item.tick_dots};
        dot_left = sum;
        line_inc = r_line + 8'd1;
        line_new = line_inc;
        cmp_now = 1'b0;

        case (i_item.operation)
            OP_READ: begin
                unique case (i_item.reg_address)
                    ADDR_CONTROL:  res.read_data = r_control;
                    ADDR_STATUS:   res.read_data = {r_status[7:2],
                                       r_control[7] ? mode_code(r_phase) : 2'b00};
                    ADDR_SCROLL_Y: res.read_data = r_scy;
                    ADDR_SCROLL_X: res.read_data = r_scx;
                    ADDR_LINE:     res.read_data = r_line;
                    ADDR_LYC:      res.read_data = r_lyc;
                    ADDR_DMA:      res.read_data = r_dma;
                    ADDR_BGP:      res.read_data = r_bgp;
                    ADDR_OBP0:     res.read_data = r_obp0;
                    ADDR_OBP1:     res.read_data = r_obp1;
                    ADDR_WIN_Y:    res.read_data = r_win_y;
                    ADDR_WIN_X:    res.read_data = r_win_x;
                    default:       res.read_data = READ_UNMAPPED;
                endcase
            end
            OP_WRITE: begin
                unique case (i_item.reg_address)
                    ADDR_CONTROL: begin
                        // Switching the display off parks the timing at line 0.
                        if (r_control[7] && !i_item.write_data[7]) begin
                            n_phase = PH_HBLANK;
                            n_dot   = '0;
                            n_line  = '0;
                        end
                        n_control = i_item.write_data;
                    end
                    ADDR_STATUS:   n_status = {i_item.write_data[7:3], r_status[2:0]};
                    ADDR_SCROLL_Y: n_scy    = i_item.write_data;
                    ADDR_SCROLL_X: n_scx    = i_item.write_data;
                    ADDR_LYC:      n_lyc    = i_item.write_data;
                    ADDR_DMA:      n_dma    = i_item.write_data;
                    ADDR_BGP:      n_bgp    = i_item.write_data;
                    ADDR_OBP0:     n_obp0   = i_item.write_data;
                    ADDR_OBP1:     n_obp1   = i_item.write_data;
                    ADDR_WIN_Y:    n_win_y  = i_item.write_data;
                    ADDR_WIN_X:    n_win_x  = i_item.write_data;
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (r_control[7]) begin
                    unique case (r_phase)
                        PH_SCAN: begin
                            if (sum >= DOTS_SCAN) begin
                                dot_left = sum - DOTS_SCAN;
                                n_phase  = PH_DRAW;
                            end
                        end
                        PH_DRAW: begin
                            if (sum >= DOTS_DRAW) begin
                                dot_left       = sum - DOTS_DRAW;
                                n_phase        = PH_HBLANK;
                                res.line_drawn = 1'b1;
                                res.stat_irq   = r_status[3];
                            end
                        end
                        PH_HBLANK: begin
                            if (sum >= DOTS_HBLANK) begin
                                dot_left = sum - DOTS_HBLANK;
                                n_line   = line_inc;
                                cmp_now  = (line_inc == r_lyc);
                                n_status[2] = cmp_now;
                                if (line_inc == LINE_VBLANK) begin
                                    n_phase        = PH_VBLANK;
                                    res.vblank_irq = 1'b1;
                                    res.frame_done = 1'b1;
                                    res.stat_irq   = r_status[4];
                                end else begin
                                    n_phase      = PH_SCAN;
                                    res.stat_irq = r_status[5];
                                end
                                if (cmp_now && !r_status[2] && r_status[6]) begin
                                    res.stat_irq = 1'b1;
                                end
                            end
                        end
                        PH_VBLANK: begin
                            if (sum >= DOTS_LINE) begin
                                dot_left = sum - DOTS_LINE;
                                if (line_inc > LINE_LAST) begin
                                    line_new     = '0;
                                    n_phase      = PH_SCAN;
                                    res.stat_irq = r_status[5];
                                end
                                n_line  = line_new;
                                cmp_now = (line_new == r_lyc);
                                n_status[2] = cmp_now;
                                if (cmp_now && !r_status[2] && r_status[6]) begin
                                    res.stat_irq = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                    n_dot = dot_left[8:0];
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_control <= RST_CONTROL;
            r_status  <= RST_STATUS;
            r_scy     <= '0;
            r_scx     <= '0;
            r_line    <= '0;
            r_lyc     <= '0;
            r_dma     <= '0;
            r_bgp     <= RST_BGP;
            r_obp0    <= RST_OBP;
            r_obp1    <= RST_OBP;
            r_win_y   <= '0;
            r_win_x   <= '0;
            r_phase   <= PH_SCAN;
            r_dot     <= '0;
        end else if (i_fire) begin
            r_control <= n_control;
            r_status  <= n_status;
            r_scy     <= n_scy;
            r_scx     <= n_scx;
            r_line    <= n_line;
            r_lyc     <= n_lyc;
            r_dma     <= n_dma;
            r_bgp     <= n_bgp;
            r_obp0    <= n_obp0;
            r_obp1    <= n_obp1;
            r_win_y   <= n_win_y;
            r_win_x   <= n_win_x;
            r_phase   <= n_phase;
            r_dot     <= n_dot;
        end
    end

    assign o_result = res;

    a_dot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot < DOTS_LINE[8:0])
        else $error("dot counter reached a full line");

    a_line_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_line <= LINE_LAST)
        else $error("line counter beyond the last line");

    a_vblank_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_VBLANK) == (r_line >= LINE_VBLANK))
        else $error("vertical blank phase out of step with the line counter");

    a_drawn_hblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && res.line_drawn) |=> (r_phase == PH_HBLANK))
        else $error("end of draw did not enter horizontal blank");

endmodule

[rtl/lmt_out_reg.sv]
// Result register stage of the LCD mode timing block.
// Depends on lmt_pkg for the result item type.
module lmt_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  lmt_pkg::t_out_item i_result,
    output logic               o_can_load,
    output logic               o_valid,
    input  logic               i_ready,
    output lmt_pkg::t_out_item o_item
);
    import lmt_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_can_load = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_result;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[rtl/lcd_mode_timing_registers.sv]
// Top level of the LCD mode timing and register block.
// Depends on lmt_pkg, lmt_in_reg, lmt_engine and lmt_out_reg.
//
//   Channel   Direction  Handshake                 Payload
//   in        input      i_in_valid / o_in_ready   i_in_item  (lmt_pkg::t_in_item)
//   out       output     o_out_valid / i_out_ready o_out_item (lmt_pkg::t_out_item)
//
// Every item gives exactly one result, taken through the input and output registers.
// One item per clock, unless stalled: the input register feeds the engine, whose
// register file and timing counters update as the result enters the output register.
// Reset (synchronous, active low) restores all display registers to their power-on
// values and empties both register stages.
// A stall on the output holds the result and, once the input register is also
// full, lowers o_in_ready; otherwise items stream at one per clock.
module lcd_mode_timing_registers (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  lmt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output lmt_pkg::t_out_item o_out_item
);
    import lmt_pkg::*;

    logic      held_valid;
    t_in_item  held_item;
    logic      out_can_load;
    logic      fire;
    t_out_item result;

    // An item moves from the input register to the output register when the
    // latter is empty or being emptied; the engine state updates on that move.
    assign fire = held_valid && out_can_load;

    lmt_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_valid (held_valid),
        .o_item  (held_item),
        .i_take  (fire)
    );

    lmt_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (held_item),
        .o_result (result)
    );

    lmt_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (result),
        .o_can_load (out_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_item     (o_out_item)
    );

    // A frame end always comes with the vertical blank request.
    a_frame_vblank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.frame_done) |-> o_out_item.vblank_irq)
        else $error("frame_done without vblank_irq");

    // Only reads carry data; a result with read data never carries timing pulses.
    a_read_no_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.read_data != 8'd0)) |->
        !(o_out_item.vblank_irq || o_out_item.stat_irq || o_out_item.line_drawn))
        else $error("read result carries a timing pulse");

    // Nothing is accepted while both stages are full and the output is stalled.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (held_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted with both stages full");

endmodule

[sim/lcd_mode_timing_registers_tb.sv]
// Self-checking testbench for lcd_mode_timing_registers: dot ticks and register traffic
// are checked against a cycle-free model of the mode timing and register file.
// Depends on lmt_pkg and the RTL of the block; needs nothing else.
`timescale 1ns / 1ps

module lcd_mode_timing_registers_tb;

    import lmt_pkg::*;

    // Operation code that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int SCRIPT_LEN     = 25;
    localparam int RANDOM_ITEMS   = 1850;
    localparam int SQUEEZE_AT     = 400;   // results seen before the long hold-off
    localparam int SQUEEZE_CYCLES = 300;   // length of the long hold-off
    localparam int DRAIN_CYCLES   = 20;    // settle time once nothing is outstanding
    localparam int STALL_LIMIT    = 3000;  // cycles without any item moving

    // Display mode as the status register encodes it.
    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_SCAN   = 2'd2,
        MODE_DRAW   = 2'd3
    } t_lcd_mode;

    // One row of the directed script. Where fixed is set, the item's result is known
    // outright: read_data equals rd and every flag is clear.
    typedef struct {
        t_in_item   item;
        bit         fixed;
        logic [7:0] rd;
    } t_script_row;

    logic      i_clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_item = '0;
    logic      out_ready = 1'b0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_item;

    // Copy of the display state, kept in step with every accepted item.
    logic [7:0] lcd_ctrl, lcd_stat, lcd_scy, lcd_scx, lcd_ly, lcd_lyc;
    logic [7:0] lcd_dma, lcd_bgp, lcd_obp0, lcd_obp1, lcd_wy, lcd_wx;
    t_lcd_mode  lcd_mode;
    logic [8:0] lcd_dots;

    // Results still owed by the block, oldest first.
    t_out_item   lcd_replies[$];
    t_script_row script[SCRIPT_LEN];

    int errors = 0;
    int results_seen = 0;
    int cycle_no = 0;
    int idle_cycles = 0;
    bit squeeze_done = 1'b0;

    lcd_mode_timing_registers dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Refreshes the line-compare flag in status bit 2. A rising flag asks for a status
    // interrupt only when the compare source (bit 6) is enabled.
    function automatic bit lyc_rise();
        bit was;
        bit now;
        was = lcd_stat[2];
        now = (lcd_ly == lcd_lyc);
        lcd_stat[2] = now;
        return now && !was && lcd_stat[6];
    endfunction

    // Applies one item to the state copy and returns the result it should give.
    task automatic lcd_step(input t_in_item it, output t_out_item res);
        int d;
        res = '0;
        case (it.operation)
            OP_READ: begin
                case (it.reg_address)
                    ADDR_CONTROL:  res.read_data = lcd_ctrl;
                    // The mode bits are live, and read as zero with the display off.
                    ADDR_STATUS:   res.read_data = {lcd_stat[7:2],
                                                    lcd_ctrl[7] ? lcd_mode : MODE_HBLANK};
                    ADDR_SCROLL_Y: res.read_data = lcd_scy;
                    ADDR_SCROLL_X: res.read_data = lcd_scx;
                    ADDR_LINE:     res.read_data = lcd_ly;
                    ADDR_LYC:      res.read_data = lcd_lyc;
                    ADDR_DMA:      res.read_data = lcd_dma;
                    ADDR_BGP:      res.read_data = lcd_bgp;
                    ADDR_OBP0:     res.read_data = lcd_obp0;
                    ADDR_OBP1:     res.read_data = lcd_obp1;
                    ADDR_WIN_Y:    res.read_data = lcd_wy;
                    ADDR_WIN_X:    res.read_data = lcd_wx;
                    default:       res.read_data = READ_UNMAPPED;
                endcase
            end
            OP_WRITE: begin
                case (it.reg_address)
                    ADDR_CONTROL: begin
                        // Switching the display off parks the timing at line 0.
                        if (lcd_ctrl[7] && !it.write_data[7]) begin
                            lcd_mode = MODE_HBLANK;
                            lcd_dots = '0;
                            lcd_ly   = '0;
                        end
                        lcd_ctrl = it.write_data;
                    end
                    ADDR_STATUS:   lcd_stat = {it.write_data[7:3], lcd_stat[2:0]};
                    ADDR_SCROLL_Y: lcd_scy  = it.write_data;
                    ADDR_SCROLL_X: lcd_scx  = it.write_data;
                    ADDR_LYC:      lcd_lyc  = it.write_data;
                    ADDR_DMA:      lcd_dma  = it.write_data;
                    ADDR_BGP:      lcd_bgp  = it.write_data;
                    ADDR_OBP0:     lcd_obp0 = it.write_data;
                    ADDR_OBP1:     lcd_obp1 = it.write_data;
                    ADDR_WIN_Y:    lcd_wy   = it.write_data;
                    ADDR_WIN_X:    lcd_wx   = it.write_data;
                    default: ;
                endcase
            end
            OP_TICK: begin
                if (lcd_ctrl[7]) begin
                    d = int'(lcd_dots) + int'(it.tick_dots);
                    // No more than one mode change per tick; surplus dots carry over.
                    case (lcd_mode)
                        MODE_SCAN: begin
                            if (d >= int'(DOTS_SCAN)) begin
                                d -= int'(DOTS_SCAN);
                                lcd_mode = MODE_DRAW;
                            end
                        end
                        MODE_DRAW: begin
                            if (d >= int'(DOTS_DRAW)) begin
                                d -= int'(DOTS_DRAW);
                                lcd_mode = MODE_HBLANK;
                                res.line_drawn = 1'b1;
                                if (lcd_stat[3]) res.stat_irq = 1'b1;
                            end
                        end
                        MODE_HBLANK: begin
                            if (d >= int'(DOTS_HBLANK)) begin
                                d -= int'(DOTS_HBLANK);
                                lcd_ly = lcd_ly + 8'd1;
                                if (lyc_rise()) res.stat_irq = 1'b1;
                                if (lcd_ly == LINE_VBLANK) begin
                                    lcd_mode = MODE_VBLANK;
                                    res.vblank_irq = 1'b1;
                                    res.frame_done = 1'b1;
                                    if (lcd_stat[4]) res.stat_irq = 1'b1;
                                end else begin
                                    lcd_mode = MODE_SCAN;
                                    if (lcd_stat[5]) res.stat_irq = 1'b1;
                                end
                            end
                        end
                        MODE_VBLANK: begin
                            if (d >= int'(DOTS_LINE)) begin
                                d -= int'(DOTS_LINE);
                                lcd_ly = lcd_ly + 8'd1;
                                if (lcd_ly > LINE_LAST) begin
                                    lcd_ly   = '0;
                                    lcd_mode = MODE_SCAN;
                                    if (lcd_stat[5]) res.stat_irq = 1'b1;
                                end
                                if (lyc_rise()) res.stat_irq = 1'b1;
                            end
                        end
                    endcase
                    lcd_dots = 9'(d);
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_script_row mk_row(logic [1:0] op, int dots, logic [15:0] addr,
                                           logic [7:0] data, bit fixed, logic [7:0] rd);
        t_script_row r;
        r.item.operation   = op;
        r.item.tick_dots   = 7'(dots);
        r.item.reg_address = addr;
        r.item.write_data  = data;
        r.fixed = fixed;
        r.rd    = rd;
        return r;
    endfunction

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int idle_len(bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    function automatic void field_check(string name, int want, int got);
        if (want != got) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // A random item. Most are ticks with many dots, so that the run passes through
    // whole frames; display-off writes are held back until late in the run, since
    // each one sends the timing back to line 0.
    function automatic t_in_item random_item(bit allow_off);
        t_in_item it;
        int r;
        r = $urandom_range(0, 999);
        it.tick_dots   = 7'($urandom_range(0, 80));
        it.reg_address = 16'($urandom);
        it.write_data  = 8'($urandom);
        if (r < 800) begin
            it.operation = OP_TICK;
            if ($urandom_range(0, 3) != 0) it.tick_dots = 7'($urandom_range(56, 80));
        end else begin
            it.operation = (r < 900) ? OP_READ : (r < 990) ? OP_WRITE : OP_UNUSED;
            if ($urandom_range(0, 19) > 2)
                it.reg_address = ADDR_CONTROL + 16'($urandom_range(0, 11));
            if (it.operation == OP_WRITE && it.reg_address == ADDR_CONTROL && !allow_off)
                it.write_data[7] = 1'b1;
        end
        return it;
    endfunction

    // Offers one item after a random gap, holds it until the block takes it, and
    // then records the result that the block owes for it.
    task automatic push_item(input t_in_item it, input bit quiet, input bit fixed,
                             input logic [7:0] rd);
        int gap;
        t_out_item owed;
        gap = idle_len(quiet);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        lcd_step(it, owed);
        if (fixed) begin
            owed = '0;
            owed.read_data = rd;
        end
        lcd_replies.push_back(owed);
    endtask

    // Receiver: short random stalls, quiet stretches now and then, and a single long
    // hold-off during which the sender keeps offering items, so that both register
    // stages fill and the block has to stall its input.
    initial begin : sink_side
        int stall;
        bit quiet;
        while (!rst_n) @(posedge i_clk);
        forever begin
            quiet = ((cycle_no / 500) % 5) == 4;
            if (!squeeze_done && results_seen >= SQUEEZE_AT) begin
                stall = SQUEEZE_CYCLES;
                squeeze_done = 1'b1;
            end else begin
                stall = idle_len(quiet);
            end
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    // Each result the block hands over is held against the oldest one owed.
    always @(posedge i_clk) begin : reply_check
        t_out_item want;
        if (rst_n && o_out_valid && out_ready) begin
            results_seen++;
            if (lcd_replies.size() == 0) begin
                $display("%0t: result with nothing owed, expected none, got %h",
                         $time, o_out_item);
                errors++;
            end else begin
                want = lcd_replies.pop_front();
                field_check("read_data", want.read_data, o_out_item.read_data);
                field_check("vblank_irq", want.vblank_irq, o_out_item.vblank_irq);
                field_check("stat_irq", want.stat_irq, o_out_item.stat_irq);
                field_check("line_drawn", want.line_drawn, o_out_item.line_drawn);
                field_check("frame_done", want.frame_done, o_out_item.frame_done);
            end
        end
    end

    // Watchdog: a run in which no item moves on either side for too long is a hang.
    always @(posedge i_clk) begin
        if (rst_n) begin
            cycle_no++;
            if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= STALL_LIMIT) begin
                    $display("%0t: no item moved for %0d cycles, %0d results owed",
                             $time, idle_cycles, lcd_replies.size());
                    $display("lcd_mode_timing_registers_tb: done, errors");
                    $finish;
                end
            end
        end
    end

    initial begin : source_side
        int n;
        // Power-on state of the display registers.
        lcd_ctrl = RST_CONTROL;
        lcd_stat = RST_STATUS;
        lcd_scy  = '0;
        lcd_scx  = '0;
        lcd_ly   = '0;
        lcd_lyc  = '0;
        lcd_dma  = '0;
        lcd_bgp  = RST_BGP;
        lcd_obp0 = RST_OBP;
        lcd_obp1 = RST_OBP;
        lcd_wy   = '0;
        lcd_wx   = '0;
        lcd_mode = MODE_SCAN;
        lcd_dots = '0;

        // Directed script: reset values, unmapped and read-only addresses, the unused
        // operation, a full scan and draw period with the draw-end interrupt enabled,
        // a status write that must keep its low bits, and the display switched off
        // and on again with a tick in between that must do nothing.
        script[0]  = mk_row(OP_READ,   0, ADDR_CONTROL,  8'h00, 1, RST_CONTROL);
        script[1]  = mk_row(OP_READ,   0, ADDR_STATUS,   8'h00, 1, 8'h86);
        script[2]  = mk_row(OP_READ,   0, ADDR_SCROLL_Y, 8'h00, 1, 8'h00);
        script[3]  = mk_row(OP_READ,   0, ADDR_BGP,      8'h00, 1, RST_BGP);
        script[4]  = mk_row(OP_READ,   0, ADDR_OBP0,     8'h00, 1, RST_OBP);
        script[5]  = mk_row(OP_READ,   0, ADDR_OBP1,     8'h00, 1, RST_OBP);
        script[6]  = mk_row(OP_READ,   0, 16'h0000,      8'h00, 1, READ_UNMAPPED);
        script[7]  = mk_row(OP_READ,   0, 16'hFFFF,      8'h00, 1, READ_UNMAPPED);
        script[8]  = mk_row(OP_WRITE,  0, ADDR_LINE,     8'hFF, 1, 8'h00);
        script[9]  = mk_row(OP_READ,   0, ADDR_LINE,     8'h00, 1, 8'h00);
        script[10] = mk_row(OP_UNUSED, 80, 16'hFFFF,     8'hFF, 1, 8'h00);
        script[11] = mk_row(OP_TICK,   0, 16'h0000,      8'h00, 0, 8'h00);
        script[12] = mk_row(OP_TICK,   80, ADDR_CONTROL, 8'h00, 0, 8'h00);
        script[13] = mk_row(OP_WRITE,  0, ADDR_STATUS,   8'hFF, 0, 8'h00);
        script[14] = mk_row(OP_READ,   0, ADDR_STATUS,   8'h00, 0, 8'h00);
        script[15] = mk_row(OP_WRITE,  0, ADDR_LYC,      8'h00, 0, 8'h00);
        script[16] = mk_row(OP_TICK,   80, 16'h0000,     8'h00, 0, 8'h00);
        script[17] = mk_row(OP_TICK,   80, 16'h0000,     8'h00, 0, 8'h00);
        script[18] = mk_row(OP_TICK,   80, 16'h0000,     8'h00, 0, 8'h00);
        script[19] = mk_row(OP_WRITE,  0, ADDR_CONTROL,  8'h00, 1, 8'h00);
        script[20] = mk_row(OP_READ,   0, ADDR_STATUS,   8'h00, 0, 8'h00);
        script[21] = mk_row(OP_TICK,   80, 16'h0000,     8'h00, 1, 8'h00);
        script[22] = mk_row(OP_WRITE,  0, ADDR_CONTROL,  8'hFF, 0, 8'h00);
        script[23] = mk_row(OP_WRITE,  0, ADDR_STATUS,   8'h00, 0, 8'h00);
        script[24] = mk_row(OP_READ,   0, ADDR_CONTROL,  8'h00, 0, 8'h00);

        // Synchronous reset, held low from time zero and then released.
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < SCRIPT_LEN; n++)
            push_item(script[n].item, 1'b0, script[n].fixed, script[n].rd);

        // Random traffic; every fifth stretch of 150 items is offered back to back.
        for (n = 0; n < RANDOM_ITEMS; n++)
            push_item(random_item(n >= (RANDOM_ITEMS * 2) / 3),
                      ((n / 150) % 5) == 4, 1'b0, 8'h00);
        in_valid <= 1'b0;

        // Wait for every owed result, then give stray results time to show up.
        while (lcd_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("lcd_mode_timing_registers_tb: done, clean");
        end else begin
            $display("lcd_mode_timing_registers_tb: done, errors");
        end
        $finish;
    end

endmodule
